// ----- rtl/sap_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sap_pkg
// Shared constants, types and the arctangent table for the sprite
// angular projection pipeline.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int MIN_SIZE_PIXELS = 4;
  localparam logic [35:0] MIN_Q8 = 36'(MIN_SIZE_PIXELS * 256);

  localparam int MAG_W  = 33;  // magnitude of a coordinate difference
  localparam int ANG_W  = 13;  // unsigned angle, Q1.12
  localparam int CX_W   = 36;  // CORDIC x/y
  localparam int CZ_W   = 18;  // CORDIC z, signed Q1.16
  localparam int SQ_W   = 62;  // sum of squares
  localparam int RT_W   = 64;  // square root working width
  localparam int DIST_W = 31;
  localparam int FOV_W  = 14;
  localparam int SCR_W  = 12;
  localparam int DIV_QW = 36;  // divider dividend and quotient

  localparam int ISQRT_LAT   = 32;
  localparam int CORDIC_ITER = 16;
  localparam int CORDIC_LAT  = CORDIC_ITER + 3;
  localparam int DIV_LAT     = DIV_QW;

  localparam logic [ANG_W-1:0]       HALF_PI_Q12 = 13'd6434;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = 18'sd102944;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FOV    = 2'd2;

  typedef enum logic [1:0] {
    VIS_ON   = 2'd0,
    VIS_NEAR = 2'd1,
    VIS_OUT  = 2'd2
  } vis_t;

  // sideband carried alongside the square root
  typedef struct packed {
    logic               draw;
    logic               hneg;
    logic               vneg;
    logic [MAG_W-1:0]   ax;
    logic [MAG_W-1:0]   ay;
    logic [MAG_W-1:0]   az;
    logic [31:0]        wsz;
    logic [31:0]        hsz;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
  } sb_sq_t;

  // sideband carried alongside the CORDIC units
  typedef struct packed {
    logic               draw;
    logic               hneg;
    logic               vneg;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
  } sb_co_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic draw;
    logic xneg;
    logic yneg;
  } sb_dv_t;

  // atan(2^-i), Q0.16, rounded to nearest
  function automatic logic signed [CZ_W-1:0] atan_tab(input int i);
    case (i)
      0:       return 18'sd51472;
      1:       return 18'sd30385;
      2:       return 18'sd16055;
      3:       return 18'sd8150;
      4:       return 18'sd4091;
      5:       return 18'sd2047;
      6:       return 18'sd1024;
      7:       return 18'sd512;
      8:       return 18'sd256;
      9:       return 18'sd128;
      10:      return 18'sd64;
      11:      return 18'sd32;
      12:      return 18'sd16;
      13:      return 18'sd8;
      14:      return 18'sd4;
      15:      return 18'sd2;
      default: return 18'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sprite_angular_projection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_angular_projection
// Angular screen projection of one sprite into a destination rectangle
// and a visibility class.
// ----------------------------------------------------------------------------
// Takes one transfer per clock and returns one result per transfer, in
// order. The depth is set by the square root (32 stages, one root bit
// each), the CORDIC arctangent units (19 stages) and the dividers by
// field_of_view (36 stages, one quotient bit each), plus 9 stages of
// setup and final arithmetic. The whole pipeline advances together: it
// stands still only while a result sits in the output register and
// out_ready is low, so in_ready = !out_valid | out_ready.
// screen_width, screen_height and field_of_view live on the APB port at
// byte addresses 0, 4 and 8 and must only be written while no transfer is
// in flight. A field_of_view of 0 is treated as 1.
// ----------------------------------------------------------------------------
module sprite_angular_projection import sap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               draw_enable,
  input  logic signed [31:0] obj_depth,
  input  logic signed [31:0] obj_up,
  input  logic signed [31:0] obj_side,
  input  logic [31:0]        obj_width,
  input  logic [31:0]        obj_height,
  input  logic signed [31:0] cam_depth,
  input  logic signed [31:0] cam_up,
  input  logic signed [31:0] cam_side,
  input  logic signed [15:0] cam_yaw,
  input  logic signed [15:0] cam_pitch,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] rect_x,
  output logic signed [15:0] rect_y,
  output logic [15:0]        rect_w,
  output logic [15:0]        rect_h,
  output logic [1:0]         visibility
);

  localparam int PIPE_DEPTH = 4 + ISQRT_LAT + CORDIC_LAT + 2 + DIV_LAT + 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SCR_W-1:0] screen_width, screen_height;
  logic [FOV_W-1:0] field_of_view, fov_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd640;
      screen_height <= 12'd480;
      field_of_view <= 14'd4096;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  screen_width  <= pwdata[SCR_W-1:0];
        REG_HEIGHT: screen_height <= pwdata[SCR_W-1:0];
        REG_FOV:    field_of_view <= pwdata[FOV_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {20'd0, screen_width};
      REG_HEIGHT: prdata = {20'd0, screen_height};
      REG_FOV:    prdata = {18'd0, field_of_view};
      default:    prdata = '0;
    endcase
  end

  assign fov_eff = (field_of_view == '0) ? 14'd1 : field_of_view;

  // --------------------------------------------------------------------------
  // Flow control: one shared advance, valid bits ride along
  // --------------------------------------------------------------------------
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  assign out_valid = vld[PIPE_DEPTH-1];

  // --------------------------------------------------------------------------
  // Stage 1: differences and magnitudes
  // --------------------------------------------------------------------------
  logic signed [MAG_W-1:0] dx, dy, dz;
  logic [MAG_W-1:0]        ax1, ay1, az1;
  logic                    hneg1, vneg1, draw1;
  logic [31:0]             ow1, oh1;
  logic signed [15:0]      yaw1, pitch1;

  assign dx = $signed({obj_depth[31], obj_depth}) - $signed({cam_depth[31], cam_depth});
  assign dy = $signed({obj_up[31], obj_up}) - $signed({cam_up[31], cam_up});
  assign dz = $signed({obj_side[31], obj_side}) - $signed({cam_side[31], cam_side});

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1    <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      ay1    <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      az1    <= dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
      // angle sign follows numerator times denominator
      hneg1  <= dz[MAG_W-1] ^ dx[MAG_W-1];
      vneg1  <= dy[MAG_W-1] ^ dx[MAG_W-1];
      draw1  <= draw_enable;
      ow1    <= obj_width;
      oh1    <= obj_height;
      yaw1   <= cam_yaw;
      pitch1 <= cam_pitch;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pre-scale by 4 when any difference reaches 2^30
  // --------------------------------------------------------------------------
  logic                big;
  logic [DIST_W-1:0]   sx2, sy2, sz2;
  sb_sq_t              sb2, sb3, sb4;
  logic [DIST_W-1:0]   sx3, sy3, sz3;
  logic [SQ_W-1:0]     qx3, qy3, qz3;
  logic [SQ_W-1:0]     vsum4;

  assign big = |(ax1[MAG_W-1:30] | ay1[MAG_W-1:30] | az1[MAG_W-1:30]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2       <= big ? ax1[DIST_W+1:2] : ax1[DIST_W-1:0];
      sy2       <= big ? ay1[DIST_W+1:2] : ay1[DIST_W-1:0];
      sz2       <= big ? az1[DIST_W+1:2] : az1[DIST_W-1:0];
      sb2.draw  <= draw1;
      sb2.hneg  <= hneg1;
      sb2.vneg  <= vneg1;
      sb2.ax    <= ax1;
      sb2.ay    <= ay1;
      sb2.az    <= az1;
      sb2.wsz   <= big ? (ow1 >> 2) : ow1;
      sb2.hsz   <= big ? (oh1 >> 2) : oh1;
      sb2.yaw   <= yaw1;
      sb2.pitch <= pitch1;
    end
  end

  // Stage 3: squares; stage 4: sum
  always_ff @(posedge clk) begin
    if (adv) begin
      qx3   <= SQ_W'(sx2 * sx2);
      qy3   <= SQ_W'(sy2 * sy2);
      qz3   <= SQ_W'(sz2 * sz2);
      sb3   <= sb2;
      vsum4 <= qx3 + qy3 + qz3;
      sb4   <= sb3;
    end
  end

  // --------------------------------------------------------------------------
  // Distance
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0] radial;
  sb_sq_t            sb_sq [0:ISQRT_LAT-1];

  sap_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .val  (vsum4),
    .root (radial)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_sq[0] <= sb4;
      for (int i = 1; i < ISQRT_LAT; i++) begin
        sb_sq[i] <= sb_sq[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Four arctangents: horizontal, vertical, width, height
  // --------------------------------------------------------------------------
  sb_sq_t           sbq;
  logic [MAG_W-1:0] dist_m;
  logic [ANG_W-1:0] ang_h, ang_v, ang_w, ang_h_sz;
  sb_co_t           sb_co [0:CORDIC_LAT-1];
  sb_co_t           sbq_co;

  assign sbq    = sb_sq[ISQRT_LAT-1];
  assign dist_m = {2'b00, radial};

  sap_cordic u_atan_h (.clk(clk), .en(adv), .num(sbq.az), .den(sbq.ax), .angle(ang_h));
  sap_cordic u_atan_v (.clk(clk), .en(adv), .num(sbq.ay), .den(sbq.ax), .angle(ang_v));
  sap_cordic u_atan_w (.clk(clk), .en(adv), .num({1'b0, sbq.wsz}), .den(dist_m),
                       .angle(ang_w));
  sap_cordic u_atan_s (.clk(clk), .en(adv), .num({1'b0, sbq.hsz}), .den(dist_m),
                       .angle(ang_h_sz));

  assign sbq_co.draw  = sbq.draw;
  assign sbq_co.hneg  = sbq.hneg;
  assign sbq_co.vneg  = sbq.vneg;
  assign sbq_co.yaw   = sbq.yaw;
  assign sbq_co.pitch = sbq.pitch;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_co[0] <= sbq_co;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        sb_co[i] <= sb_co[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P1: signed angles relative to the camera
  // P2: angle magnitude times screen width
  // --------------------------------------------------------------------------
  sb_co_t                 sbc;
  logic signed [17:0]     ha_s, va_s, ha_p1, va_p1;
  logic [ANG_W-1:0]       sw_p1, sh_p1;
  logic                   draw_p1;
  logic [17:0]            ham, vam;
  logic [27:0]            px2, py2, pw2, ph2;
  sb_dv_t                 sb_p2;

  assign sbc  = sb_co[CORDIC_LAT-1];
  assign ha_s = sbc.hneg ? -$signed({5'd0, ang_h}) : $signed({5'd0, ang_h});
  assign va_s = sbc.vneg ? -$signed({5'd0, ang_v}) : $signed({5'd0, ang_v});

  always_ff @(posedge clk) begin
    if (adv) begin
      ha_p1   <= ha_s - 18'(sbc.yaw);
      va_p1   <= va_s - 18'(sbc.pitch);
      sw_p1   <= ang_w;
      sh_p1   <= ang_h_sz;
      draw_p1 <= sbc.draw;
    end
  end

  assign ham = ha_p1[17] ? 18'(-ha_p1) : 18'(ha_p1);
  assign vam = va_p1[17] ? 18'(-va_p1) : 18'(va_p1);

  always_ff @(posedge clk) begin
    if (adv) begin
      px2        <= ham[15:0] * screen_width;
      py2        <= vam[15:0] * screen_width;
      pw2        <= 28'(sw_p1 * screen_width);
      ph2        <= 28'(sh_p1 * screen_width);
      sb_p2.draw <= draw_p1;
      sb_p2.xneg <= ha_p1[17];
      sb_p2.yneg <= va_p1[17];
    end
  end

  // --------------------------------------------------------------------------
  // Divide by field of view (Q.8 pixels)
  // --------------------------------------------------------------------------
  logic [DIV_QW-1:0] qx, qy, qw, qh;
  sb_dv_t            sb_dv [0:DIV_LAT-1];

  sap_div u_div_x (.clk(clk), .en(adv), .num({px2, 8'd0}), .den(fov_eff), .quo(qx));
  sap_div u_div_y (.clk(clk), .en(adv), .num({py2, 8'd0}), .den(fov_eff), .quo(qy));
  sap_div u_div_w (.clk(clk), .en(adv), .num({pw2, 8'd0}), .den(fov_eff), .quo(qw));
  sap_div u_div_h (.clk(clk), .en(adv), .num({ph2, 8'd0}), .den(fov_eff), .quo(qh));

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_dv[0] <= sb_p2;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_dv[i] <= sb_dv[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // F1: edges in Q.9, sizes floored at the minimum
  // --------------------------------------------------------------------------
  sb_dv_t             sbd;
  logic signed [39:0] xq8, yq8, x2n, y2n, x2_f1, y2_f1;
  logic [DIV_QW-1:0]  wq8, hq8;
  logic [15:0]        rw_f1, rh_f1, rw_f2, rh_f2;
  logic               draw_f1, draw_f2;

  assign sbd = sb_dv[DIV_LAT-1];
  assign xq8 = sbd.xneg ? -$signed({4'd0, qx}) : $signed({4'd0, qx});
  assign yq8 = sbd.yneg ? -$signed({4'd0, qy}) : $signed({4'd0, qy});
  assign wq8 = (qw < MIN_Q8) ? MIN_Q8 : qw;
  assign hq8 = (qh < MIN_Q8) ? MIN_Q8 : qh;
  assign x2n = 40'sd256 + $signed({20'd0, screen_width, 8'd0}) - $signed({4'd0, wq8})
               + (xq8 <<< 1);
  assign y2n = 40'sd256 + $signed({20'd0, screen_height, 8'd0}) - $signed({4'd0, hq8})
               - (yq8 <<< 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_f1   <= x2n;
      y2_f1   <= y2n;
      rw_f1   <= (wq8[DIV_QW-1:24] != '0) ? 16'hFFFF : wq8[23:8];
      rh_f1   <= (hq8[DIV_QW-1:24] != '0) ? 16'hFFFF : hq8[23:8];
      draw_f1 <= sbd.draw;
    end
  end

  // F2: divide by 512, truncating toward zero
  logic signed [39:0] x2r, y2r;
  logic signed [30:0] rx_f2, ry_f2;

  assign x2r = x2_f1[39] ? ((x2_f1 + 40'sd511) >>> 9) : (x2_f1 >>> 9);
  assign y2r = y2_f1[39] ? ((y2_f1 + 40'sd511) >>> 9) : (y2_f1 >>> 9);

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_f2   <= x2r[30:0];
      ry_f2   <= y2r[30:0];
      rw_f2   <= rw_f1;
      rh_f2   <= rh_f1;
      draw_f2 <= draw_f1;
    end
  end

  // --------------------------------------------------------------------------
  // F3: visibility against the 1/10 and 1/8 margins, saturation, output reg
  // --------------------------------------------------------------------------
  logic signed [35:0] rx36, ry36, wS, hS;
  logic signed [35:0] tx10, ty10, tx8, ty8, w9, w7, h10w, h8w;
  logic               is_out, is_near;
  vis_t               vis_n;
  logic signed [15:0] sx_n, sy_n;

  assign rx36 = 36'(rx_f2);
  assign ry36 = 36'(ry_f2);
  assign wS   = $signed({24'd0, screen_width});
  assign hS   = $signed({24'd0, screen_height});
  assign tx10 = (rx36 <<< 3) + (rx36 <<< 1);
  assign ty10 = (ry36 <<< 3) + (ry36 <<< 1);
  assign tx8  = rx36 <<< 3;
  assign ty8  = ry36 <<< 3;
  assign w9   = (wS <<< 3) + wS;
  assign w7   = (wS <<< 3) - wS;
  assign h10w = (hS <<< 3) + (hS <<< 1) - wS;
  assign h8w  = (hS <<< 3) - wS;

  assign is_out  = (tx10 < wS) || (ty10 < wS) || (tx10 > w9) || (ty10 > h10w);
  assign is_near = (tx8 < wS) || (ty8 < wS) || (tx8 > w7) || (ty8 > h8w);

  always_comb begin
    if (!draw_f2 || is_out) begin
      vis_n = VIS_OUT;
    end else if (is_near) begin
      vis_n = VIS_NEAR;
    end else begin
      vis_n = VIS_ON;
    end
    if (rx_f2 > 31'sd32767) begin
      sx_n = 16'sh7FFF;
    end else if (rx_f2 < -31'sd32768) begin
      sx_n = 16'sh8000;
    end else begin
      sx_n = rx_f2[15:0];
    end
    if (ry_f2 > 31'sd32767) begin
      sy_n = 16'sh7FFF;
    end else if (ry_f2 < -31'sd32768) begin
      sy_n = 16'sh8000;
    end else begin
      sy_n = ry_f2[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rect_x     <= draw_f2 ? sx_n : '0;
      rect_y     <= draw_f2 ? sy_n : '0;
      rect_w     <= draw_f2 ? rw_f2 : '0;
      rect_h     <= draw_f2 ? rh_f2 : '0;
      visibility <= vis_n;
    end
  end

`ifndef SYNTH
  // a stalled pipeline holds every valid bit in place
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("valid pipe moved during stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a drawn sprite is never smaller than the minimum
  a_min_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (visibility != VIS_OUT) |->
      (rect_w >= 16'(MIN_SIZE_PIXELS)) && (rect_h >= 16'(MIN_SIZE_PIXELS)))
    else $error("drawn rectangle below minimum size");

  // an empty rectangle only comes with out of screen
  a_zero_rect: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rect_w == '0) |-> (visibility == VIS_OUT))
    else $error("zero rectangle not out of screen");
`endif

endmodule
`default_nettype wire

// ----- rtl/sap_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sap_isqrt
// Pipelined integer square root, truncated, one result bit per stage.
// ----------------------------------------------------------------------------
module sap_isqrt import sap_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   val,
  output logic [DIST_W-1:0] root
);

  logic [RT_W-1:0] rv [0:ISQRT_LAT-1];
  logic [RT_W-1:0] rr [0:ISQRT_LAT-1];

  for (genvar k = 0; k < ISQRT_LAT; k++) begin : g_st
    logic [RT_W-1:0] v_src, r_src, bb, t;
    if (k == 0) begin : g_first
      assign v_src = RT_W'(val);
      assign r_src = '0;
    end else begin : g_next
      assign v_src = rv[k-1];
      assign r_src = rr[k-1];
    end
    assign bb = RT_W'(1) << (2 * (ISQRT_LAT - 1 - k));
    assign t  = r_src + bb;

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_src >= t) begin
          rv[k] <= v_src - t;
          rr[k] <= (r_src >> 1) + bb;
        end else begin
          rv[k] <= v_src;
          rr[k] <= r_src >> 1;
        end
      end
    end
  end

  assign root = rr[ISQRT_LAT-1][DIST_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/sap_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sap_cordic
// Pipelined atan(num/den) for magnitudes: two normalize stages, sixteen
// vectoring iterations, one clamp and round stage. Result Q1.12.
// ----------------------------------------------------------------------------
module sap_cordic import sap_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] num,
  input  logic [MAG_W-1:0] den,
  output logic [ANG_W-1:0] angle
);

  logic [MAG_W-1:0] v0, n1, d1, v1, n2, d2;
  logic             sh16, sh8;
  logic [MAG_W-1:0] num_a, den_a;
  logic             spec_a;
  logic [ANG_W-1:0] sval_a;

  logic [MAG_W-1:0] va, n3, d3, v3, n4, d4, v4, n5, d5;
  logic             sh4, sh2, sh1;

  logic signed [CX_W-1:0] cx [0:CORDIC_ITER];
  logic signed [CX_W-1:0] cy [0:CORDIC_ITER];
  logic signed [CZ_W-1:0] cz [0:CORDIC_ITER];
  logic                   spec [0:CORDIC_ITER];
  logic [ANG_W-1:0]       sval [0:CORDIC_ITER];

  logic signed [CZ_W-1:0] zc, zr;

  // normalize, coarse steps
  always_comb begin
    v0   = num | den;
    sh16 = (v0[MAG_W-1:16] == '0);
    n1   = sh16 ? (num << 16) : num;
    d1   = sh16 ? (den << 16) : den;
    v1   = n1 | d1;
    sh8  = (v1[MAG_W-1:24] == '0);
    n2   = sh8 ? (n1 << 8) : n1;
    d2   = sh8 ? (d1 << 8) : d1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a  <= n2;
      den_a  <= d2;
      spec_a <= (den == '0) || (num == '0);
      sval_a <= (den == '0 && num != '0) ? HALF_PI_Q12 : '0;
    end
  end

  // normalize, fine steps
  always_comb begin
    va  = num_a | den_a;
    sh4 = (va[MAG_W-1:28] == '0);
    n3  = sh4 ? (num_a << 4) : num_a;
    d3  = sh4 ? (den_a << 4) : den_a;
    v3  = n3 | d3;
    sh2 = (v3[MAG_W-1:30] == '0);
    n4  = sh2 ? (n3 << 2) : n3;
    d4  = sh2 ? (d3 << 2) : d3;
    v4  = n4 | d4;
    sh1 = (v4[MAG_W-1:31] == '0);
    n5  = sh1 ? (n4 << 1) : n4;
    d5  = sh1 ? (d4 << 1) : d4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= $signed({3'b000, d5});
      cy[0]   <= $signed({3'b000, n5});
      cz[0]   <= '0;
      spec[0] <= spec_a;
      sval[0] <= sval_a;
    end
  end

  for (genvar k = 0; k < CORDIC_ITER; k++) begin : g_it
    logic signed [CX_W-1:0] xs, ys;
    assign xs = cx[k] >>> k;
    assign ys = cy[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[k][CX_W-1]) begin
          cx[k+1] <= cx[k] + ys;
          cy[k+1] <= cy[k] - xs;
          cz[k+1] <= cz[k] + atan_tab(k);
        end else begin
          cx[k+1] <= cx[k] - ys;
          cy[k+1] <= cy[k] + xs;
          cz[k+1] <= cz[k] - atan_tab(k);
        end
        spec[k+1] <= spec[k];
        sval[k+1] <= sval[k];
      end
    end
  end

  // clamp to [0, pi/2] then round Q1.16 to Q1.12
  always_comb begin
    if (cz[CORDIC_ITER] < 0) begin
      zc = '0;
    end else if (cz[CORDIC_ITER] > HALF_PI_Q16) begin
      zc = HALF_PI_Q16;
    end else begin
      zc = cz[CORDIC_ITER];
    end
    zr = (zc + 18'sd8) >>> 4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= spec[CORDIC_ITER] ? sval[CORDIC_ITER] : zr[ANG_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sap_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sap_div
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sap_div import sap_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_QW-1:0] num,
  input  logic [FOV_W-1:0]  den,
  output logic [DIV_QW-1:0] quo
);

  logic [DIV_QW-1:0] nq [0:DIV_LAT-1];
  logic [FOV_W-1:0]  rq [0:DIV_LAT-1];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_st
    logic [DIV_QW-1:0] n_src;
    logic [FOV_W-1:0]  r_src;
    logic [FOV_W:0]    trial, diff;
    logic              ge;
    if (k == 0) begin : g_first
      assign n_src = num;
      assign r_src = '0;
    end else begin : g_next
      assign n_src = nq[k-1];
      assign r_src = rq[k-1];
    end
    assign trial = {r_src, n_src[DIV_QW-1]};
    assign ge    = (trial >= {1'b0, den});
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rq[k] <= ge ? diff[FOV_W-1:0] : trial[FOV_W-1:0];
        nq[k] <= {n_src[DIV_QW-2:0], ge};
      end
    end
  end

  assign quo = nq[DIV_LAT-1];

endmodule
`default_nettype wire
